### hdl/wgtg_pkg.sv
// Package with widths, constants and types shared by the waypoint controller.
package wgtg_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_STEPS_MAX = 24;
    localparam int ZW = 20;
    localparam int XYW = 24;
    localparam logic signed [15:0] PI_Q13 = 16'sd25736;
    localparam logic signed [17:0] TWO_PI_Q13 = 18'sd51472;
    localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;

    localparam logic [2:0] REG_DIST_START = 3'd0;
    localparam logic [2:0] REG_DIST_STOP = 3'd1;
    localparam logic [2:0] REG_ANG_START = 3'd2;
    localparam logic [2:0] REG_ANG_STOP = 3'd3;
    localparam logic [2:0] REG_HEAD_DONE = 3'd4;
    localparam logic [2:0] REG_TURN_GAIN = 3'd5;
    localparam logic [2:0] REG_DRIVE_GAIN = 3'd6;

    localparam logic OP_SET_GOAL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic signed [XYW-1:0] x;
        logic signed [XYW-1:0] y;
        logic signed [ZW-1:0]  z;
    } t_vec;

    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                0: v = 20'sd51472;
                1: v = 20'sd30386;
                2: v = 20'sd16055;
                3: v = 20'sd8150;
                4: v = 20'sd4091;
                5: v = 20'sd2047;
                6: v = 20'sd1024;
                7: v = 20'sd512;
                8: v = 20'sd256;
                9: v = 20'sd128;
                10: v = 20'sd64;
                11: v = 20'sd32;
                12: v = 20'sd16;
                13: v = 20'sd8;
                14: v = 20'sd4;
                15: v = 20'sd2;
                16: v = 20'sd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

### hdl/wgtg_cell.sv
// One CORDIC vectoring stage with a fixed shift, registered toward its neighbor.
module wgtg_cell import wgtg_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic i_clk,
    input  t_vec i_vec,
    output t_vec o_vec
);
    t_vec n_vec;
    t_vec r_vec;
    logic signed [XYW-1:0] xs;
    logic signed [XYW-1:0] ys;

    always_comb begin
        xs = i_vec.x >>> STAGE;
        ys = i_vec.y >>> STAGE;
        if (i_vec.y > 0) begin
            n_vec.x = i_vec.x + ys;
            n_vec.y = i_vec.y - xs;
            n_vec.z = i_vec.z + atan_q16(STAGE);
        end else begin
            n_vec.x = i_vec.x - ys;
            n_vec.y = i_vec.y + xs;
            n_vec.z = i_vec.z - atan_q16(STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec <= n_vec;
    end

    assign o_vec = r_vec;
endmodule

### hdl/wgtg_isqrt.sv
// Iterative square root of a 34-bit radicand; a start while busy abandons the current root and begins a new one.
module wgtg_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_n,
    output logic        o_done,
    output logic [16:0] o_root
);
    logic [33:0] r_n, n_n;
    logic [33:0] r_r, n_r;
    logic [33:0] r_bit, n_bit;
    logic        r_busy, n_busy;
    logic        r_done;
    logic [33:0] sum;

    always_comb begin
        sum = r_r + r_bit;
        n_n = r_n;
        n_r = r_r;
        n_bit = r_bit;
        n_busy = r_busy;
        if (i_start) begin
            n_n = i_n;
            n_r = '0;
            n_bit = 34'h1_0000_0000;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_n >= sum) begin
                n_n = r_n - sum;
                n_r = (r_r >> 1) + r_bit;
            end else begin
                n_r = r_r >> 1;
            end
            n_bit = r_bit >> 2;
            if (r_bit[0]) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !n_busy;
        end
        r_n <= n_n;
        r_r <= n_r;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_r[16:0];
endmodule

### hdl/waypoint_go_to_goal_controller.sv
// Top level of the turn-then-drive waypoint controller.
// A set-goal request is taken and gives no result. A tick request gives one result:
// the calculation waits for the longer of the square root and the pass through the
// cell chain (16 CORDIC steps by default), then the request moves through the flags
// step, the command step and the output register. A result that cannot leave holds
// the block in its output step until the output register is free. One request is
// worked on at a time; a new one is accepted while the previous result still waits
// in the output register.
module waypoint_go_to_goal_controller import wgtg_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_operation,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [14:0]        o_linear_speed,
    output logic signed [15:0] o_turn_rate,
    output logic               o_active,
    output logic               o_reached,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CALC  = 5'b00010,
        S_FLAGS = 5'b00100,
        S_CMD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    localparam int NS = (CORDIC_STEPS < 1) ? 1 : CORDIC_STEPS;
    localparam int CW = $clog2(NS + 2);

    t_state r_state, n_state;
    logic [15:0] r_dstart, r_dstop, r_tgain, r_dgain;
    logic [14:0] r_astart, r_astop, r_hdone;
    logic signed [15:0] r_gx, r_gy, r_gh, r_hd;
    logic r_act, r_lmet, r_amet;
    logic [14:0] r_lin;
    logic signed [15:0] r_turn;
    logic r_ovalid;
    logic [14:0] r_olin;
    logic signed [15:0] r_oturn;
    logic r_oact, r_orch;
    logic [CW-1:0] r_cnt;
    logic r_sq_done;
    logic [16:0] r_dist;
    logic signed [17:0] r_a, r_fin;
    logic signed [16:0] dx, dy;
    logic [33:0] sq;
    logic sq_done;
    logic [16:0] root;
    logic accept;
    logic out_free;
    t_vec pre;
    t_vec chain [0:NS];
    logic signed [ZW-1:0] zf;
    logic signed [17:0] bear, err, fin, sel_a;
    logic [17:0] abs_a, abs_fin;
    logic lmet_n, amet_n;
    logic signed [35:0] tprod;
    logic [33:0] lprod;
    logic signed [19:0] tp;
    logic [17:0] lp;

    assign accept = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign o_ready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign dx = 17'(r_gx) - 17'(i_pos_x);
    assign dy = 17'(r_gy) - 17'(i_pos_y);
    assign sq = 34'(dx * dx) + 34'(dy * dy);

    wgtg_isqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && i_operation != OP_SET_GOAL),
        .i_n     (sq),
        .o_done  (sq_done),
        .o_root  (root)
    );

    always_comb begin
        pre.x = XYW'(dx);
        pre.y = XYW'(dy);
        pre.z = '0;
        if (dx < 0) begin
            if (dy >= 0) begin
                pre.x = XYW'(dy);
                pre.y = -XYW'(dx);
                pre.z = HALF_PI_Q16;
            end else begin
                pre.x = -XYW'(dy);
                pre.y = XYW'(dx);
                pre.z = -HALF_PI_Q16;
            end
        end
    end

    t_vec r_pre;
    logic r_zero;
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pre <= pre;
            r_zero <= (dx == 0) && (dy == 0);
        end
    end
    assign chain[0] = r_pre;

    genvar g;
    generate
        for (g = 0; g < NS; g++) begin : g_cell
            wgtg_cell #(.STAGE(g)) u_cell (
                .i_clk (i_clk),
                .i_vec (chain[g]),
                .o_vec (chain[g+1])
            );
        end
    endgenerate

    always_comb begin
        zf = (CORDIC_STEPS < 1) ? r_pre.z : chain[NS].z;
        bear = r_zero ? '0 : 18'((zf + ZW'(4)) >>> 3);
        err = bear - 18'(r_hd);
        if (err > 18'(PI_Q13)) begin
            err = err - TWO_PI_Q13;
        end
        if (err < -18'(PI_Q13)) begin
            err = err + TWO_PI_Q13;
        end
        fin = 18'(r_gh) - 18'(r_hd);
        if (r_dist >= 17'(r_dstart)) begin
            lmet_n = 1'b0;
        end else if (r_dist < 17'(r_dstop)) begin
            lmet_n = 1'b1;
        end else begin
            lmet_n = r_lmet;
        end
        sel_a = lmet_n ? fin : err;
        abs_a = sel_a[17] ? 18'(-sel_a) : 18'(sel_a);
        if (abs_a > 18'(r_astart)) begin
            amet_n = 1'b0;
        end else if (abs_a < 18'(r_astop)) begin
            amet_n = 1'b1;
        end else begin
            amet_n = r_amet;
        end
        abs_fin = r_fin[17] ? 18'(-r_fin) : 18'(r_fin);
        tprod = $signed({1'b0, r_tgain}) * r_a + 36'sd32768;
        lprod = r_dgain * r_dist + 34'd32768;
        tp = 20'(tprod >>> 16);
        lp = lprod[33:16];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_operation != OP_SET_GOAL) n_state = S_CALC;
            end
            S_CALC: begin
                if ((r_sq_done || sq_done) && r_cnt == CW'(NS + 1)) n_state = S_FLAGS;
            end
            S_FLAGS: n_state = S_CMD;
            S_CMD: n_state = S_OUT;
            S_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dstart <= 16'd13;
            r_dstop <= 16'd8;
            r_astart <= 15'd1229;
            r_astop <= 15'd819;
            r_hdone <= 15'd410;
            r_tgain <= 16'd19661;
            r_dgain <= 16'd32768;
            r_gx <= '0;
            r_gy <= '0;
            r_gh <= '0;
            r_act <= 1'b0;
            r_lmet <= 1'b1;
            r_amet <= 1'b1;
            r_lin <= '0;
            r_turn <= '0;
            r_ovalid <= 1'b0;
            r_cnt <= '0;
            r_sq_done <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_DIST_START: r_dstart <= i_cfg_data;
                    REG_DIST_STOP: r_dstop <= i_cfg_data;
                    REG_ANG_START: r_astart <= i_cfg_data[14:0];
                    REG_ANG_STOP: r_astop <= i_cfg_data[14:0];
                    REG_HEAD_DONE: r_hdone <= i_cfg_data[14:0];
                    REG_TURN_GAIN: r_tgain <= i_cfg_data;
                    REG_DRIVE_GAIN: r_dgain <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (accept) begin
                r_hd <= i_heading;
                r_cnt <= '0;
                r_sq_done <= 1'b0;
                if (i_operation == OP_SET_GOAL) begin
                    r_gx <= i_pos_x;
                    r_gy <= i_pos_y;
                    r_gh <= i_heading;
                    r_act <= 1'b1;
                end
            end
            case (r_state)
                S_CALC: begin
                    if (r_cnt != CW'(NS + 1)) r_cnt <= r_cnt + 1'b1;
                    if (sq_done) begin
                        r_sq_done <= 1'b1;
                        r_dist <= root;
                    end
                end
                S_FLAGS: begin
                    r_lmet <= lmet_n;
                    r_amet <= amet_n;
                    r_a <= sel_a;
                    r_fin <= fin;
                end
                S_CMD: begin
                    if (r_act && !r_amet) begin
                        r_turn <= (tp > 20'sd32767) ? 16'sd32767 :
                                  (tp < -20'sd32768) ? -16'sd32768 : tp[15:0];
                        r_lin <= '0;
                    end else if (r_act && r_dist >= 17'(r_dstart) && !r_lmet) begin
                        r_lin <= (lp > 18'd32767) ? 15'd32767 : lp[14:0];
                        r_turn <= '0;
                    end else begin
                        r_lmet <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        if (r_lmet && abs_fin < 18'(r_hdone)) begin
                            r_act <= 1'b0;
                            r_lin <= '0;
                            r_turn <= '0;
                            r_olin <= '0;
                            r_oturn <= '0;
                            r_oact <= 1'b0;
                            r_orch <= 1'b1;
                        end else begin
                            r_olin <= r_lin;
                            r_oturn <= r_turn;
                            r_oact <= r_act;
                            r_orch <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_linear_speed = r_olin;
    assign o_turn_rate = r_oturn;
    assign o_active = r_oact;
    assign o_reached = r_orch;
endmodule

### test/testbench.sv
// Self-checking testbench for the turn-then-drive waypoint controller.
`timescale 1ns / 100ps

module testbench import wgtg_pkg::*;;

    typedef struct packed {
        logic [14:0]        linear;
        logic signed [15:0] turn;
        logic               active;
        logic               reached;
    } t_cmd;

    typedef struct {
        logic               op;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] hd;
        bit                 has_cmd;
        t_cmd               cmd;
    } t_row;

    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int NUM_RANDOM = 500;
    localparam int SETTLE_CYCLES = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic               i_operation;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic signed [15:0] i_heading;
    logic               o_valid;
    logic               i_ready;
    logic [14:0]        o_linear_speed;
    logic signed [15:0] o_turn_rate;
    logic               o_active;
    logic               o_reached;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    waypoint_go_to_goal_controller uut (.*);

    // Controller state mirrored for prediction.
    longint dist_start, dist_stop, ang_start, ang_stop, head_done, turn_gain, drive_gain;
    longint goal_x, goal_y, goal_hd;
    bit     wp_active, loc_met, ang_met;
    longint last_lin, last_turn;

    t_cmd   cmd_queue[$];
    t_cmd   fixed_cmd[$];
    bit     fixed_known[$];
    int     mismatches;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >= 0 ? v >>> s : -(((-(v + 1))) >>> s) - 1;
    endfunction

    function automatic longint int_sqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic longint bearing(longint dx, longint dy);
        longint x, y, z, t, xs, ys;
        longint atans[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                              256, 128, 64, 32, 16, 8, 4, 2, 1};
        if (dx == 0 && dy == 0) return 0;
        x = dx;
        y = dy;
        z = 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 102944;
            end else begin
                t = x; x = -y; y = t; z = -102944;
            end
        end
        for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += atans[i];
            end else begin
                x -= ys; y += xs; z -= atans[i];
            end
        end
        return floor_shift(z + 4, 3);
    endfunction

    function automatic longint magn(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void reset_model();
        dist_start = 13; dist_stop = 8; ang_start = 1229; ang_stop = 819;
        head_done = 410; turn_gain = 19661; drive_gain = 32768;
        goal_x = 0; goal_y = 0; goal_hd = 0;
        wp_active = 0; loc_met = 1; ang_met = 1; last_lin = 0; last_turn = 0;
    endfunction

    function automatic void write_model_reg(logic [2:0] idx, logic [15:0] d);
        case (idx)
            REG_DIST_START: dist_start = d;
            REG_DIST_STOP: dist_stop = d;
            REG_ANG_START: ang_start = d[14:0];
            REG_ANG_STOP: ang_stop = d[14:0];
            REG_HEAD_DONE: head_done = d[14:0];
            REG_TURN_GAIN: turn_gain = d;
            REG_DRIVE_GAIN: drive_gain = d;
            default: ;
        endcase
    endfunction

    function automatic bit steer(logic op, longint px, longint py, longint hd, output t_cmd c);
        longint dx, dy, distance, err, fin, a, p;
        bit reached;
        reached = 0;
        if (op == OP_SET_GOAL) begin
            goal_x = px; goal_y = py; goal_hd = hd; wp_active = 1;
            return 0;
        end
        dx = goal_x - px;
        dy = goal_y - py;
        distance = int_sqrt(dx * dx + dy * dy);
        err = bearing(dx, dy) - hd;
        if (err > 25736) err -= 51472;
        if (err < -25736) err += 51472;
        fin = goal_hd - hd;
        if (distance >= dist_start) loc_met = 0;
        else if (distance < dist_stop) loc_met = 1;
        a = loc_met ? fin : err;
        if (magn(a) > ang_start) ang_met = 0;
        else if (magn(a) < ang_stop) ang_met = 1;
        if (wp_active && !ang_met) begin
            p = floor_shift(turn_gain * a + 32768, 16);
            if (p > 32767) p = 32767;
            if (p < -32768) p = -32768;
            last_turn = p; last_lin = 0;
        end else if (wp_active && distance >= dist_start && !loc_met) begin
            p = (drive_gain * distance + 32768) >>> 16;
            if (p > 32767) p = 32767;
            last_lin = p; last_turn = 0;
        end else begin
            loc_met = 1;
        end
        if (loc_met && magn(fin) < head_done) begin
            wp_active = 0; last_lin = 0; last_turn = 0; reached = 1;
        end
        c.linear = last_lin[14:0];
        c.turn = last_turn[15:0];
        c.active = wp_active;
        c.reached = reached;
        return 1;
    endfunction

    task automatic send_request(logic op, logic signed [15:0] px, logic signed [15:0] py,
                                logic signed [15:0] hd, bit has_fixed, t_cmd fixed);
        t_cmd c;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_pos_x <= px;
        i_pos_y <= py;
        i_heading <= hd;
        do @(posedge i_clk); while (!o_ready);
        if (steer(op, px, py, hd, c)) begin
            cmd_queue = {cmd_queue, c};
            fixed_known = {fixed_known, has_fixed};
            fixed_cmd = {fixed_cmd, fixed};
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        write_model_reg(idx, d);
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (cmd_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic void report(string what, longint expv, longint actv);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch in %s: expected %0d, actual %0d", what, expv, actv);
    endfunction

    // Receiver: random stalls and comparison against the oldest expectation.
    initial begin
        t_cmd e;
        t_cmd f;
        bit k;
        int stall;
        i_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (cmd_queue.size() == 0) begin
                report("unexpected result", 0, 1);
            end else begin
                e = cmd_queue.pop_front();
                f = fixed_cmd.pop_front();
                k = fixed_known.pop_front();
                if (k && f != e) report("directed row versus prediction", 0, 1);
                if (o_linear_speed !== e.linear) report("linear_speed", e.linear, o_linear_speed);
                if (o_turn_rate !== e.turn) report("turn_rate", e.turn, o_turn_rate);
                if (o_active !== e.active) report("active", e.active, o_active);
                if (o_reached !== e.reached) report("reached", e.reached, o_reached);
            end
        end
    end

    initial begin
        t_row rows[$];
        t_cmd none;
        t_cmd stop_cmd;
        logic signed [15:0] gx, gy, gh, off;
        none = '{0, 0, 0, 0};
        stop_cmd = '{0, 0, 0, 1};
        mismatches = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = OP_TICK;
        i_pos_x = '0;
        i_pos_y = '0;
        i_heading = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{OP_TICK, 16'sd0, 16'sd0, 16'sd0, 1, stop_cmd},
            '{OP_SET_GOAL, 16'sd0, 16'sd0, 16'sd0, 0, none},
            '{OP_TICK, 16'sd0, 16'sd0, 16'sd0, 1, stop_cmd},
            '{OP_SET_GOAL, 16'sd32767, 16'sd32767, 16'sd32767, 0, none},
            '{OP_TICK, -16'sd32768, -16'sd32768, -16'sd32768, 0, none},
            '{OP_TICK, -16'sd32768, 16'sd32767, 16'sd0, 0, none},
            '{OP_TICK, 16'sd32767, -16'sd32768, 16'sd25736, 0, none},
            '{OP_SET_GOAL, -16'sd32768, -16'sd32768, -16'sd32768, 0, none},
            '{OP_TICK, 16'sd32767, 16'sd32767, 16'sd32767, 0, none},
            '{OP_TICK, -16'sd32768, -16'sd32768, 16'sd0, 0, none},
            '{OP_TICK, -16'sd32768, -16'sd32768, -16'sd32768, 1, stop_cmd},
            '{OP_SET_GOAL, 16'sd100, 16'sd0, 16'sd0, 0, none},
            '{OP_TICK, 16'sd0, 16'sd0, 16'sd0, 0, none},
            '{OP_TICK, 16'sd0, 16'sd0, 16'sd0, 0, none},
            '{OP_TICK, 16'sd96, 16'sd0, 16'sd0, 1, stop_cmd},
            '{OP_SET_GOAL, -16'sd200, 16'sd50, 16'sd5000, 0, none},
            '{OP_TICK, 16'sd0, 16'sd0, -16'sd20000, 0, none},
            '{OP_TICK, 16'sd0, 16'sd0, 16'sd20000, 0, none},
            '{OP_TICK, -16'sd200, 16'sd50, 16'sd0, 0, none},
            '{OP_TICK, -16'sd200, 16'sd50, 16'sd5000, 1, stop_cmd}
        };
        foreach (rows[r])
            send_request(rows[r].op, rows[r].px, rows[r].py, rows[r].hd,
                         rows[r].has_cmd, rows[r].cmd);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_DIST_START, 16'hFFFF);
                    write_reg(REG_DIST_STOP, 16'hFFFF);
                    write_reg(REG_ANG_START, 16'h7FFF);
                    write_reg(REG_ANG_STOP, 16'h7FFF);
                    write_reg(REG_HEAD_DONE, 16'h7FFF);
                    write_reg(REG_TURN_GAIN, 16'hFFFF);
                    write_reg(REG_DRIVE_GAIN, 16'hFFFF);
                    write_reg(REG_UNUSED, 16'h1234);
                end
                1: begin
                    write_reg(REG_DIST_START, 16'd0);
                    write_reg(REG_DIST_STOP, 16'd0);
                    write_reg(REG_ANG_START, 16'd0);
                    write_reg(REG_ANG_STOP, 16'd0);
                    write_reg(REG_HEAD_DONE, 16'd0);
                    write_reg(REG_TURN_GAIN, 16'd0);
                    write_reg(REG_DRIVE_GAIN, 16'd0);
                end
                default: begin
                    write_reg(REG_DIST_START, 16'($urandom_range(0, 4000)));
                    write_reg(REG_DIST_STOP, 16'($urandom_range(0, 3000)));
                    write_reg(REG_ANG_START, 16'($urandom_range(0, 4000)));
                    write_reg(REG_ANG_STOP, 16'($urandom_range(0, 3000)));
                    write_reg(REG_HEAD_DONE, 16'($urandom_range(0, 2000)));
                    write_reg(REG_TURN_GAIN, 16'($urandom_range(0, 65535)));
                    write_reg(REG_DRIVE_GAIN, 16'($urandom_range(0, 65535)));
                end
            endcase
            for (int n = 0; n < NUM_RANDOM / 5; ) begin
                if ($urandom_range(0, 9) < 2) begin
                    send_request(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                                 16'($urandom), 0, none);
                    n++;
                end else begin
                    gx = 16'($urandom); gy = 16'($urandom); gh = 16'($urandom);
                    send_request(OP_SET_GOAL, gx, gy, gh, 0, none);
                    n++;
                    for (int t = $urandom_range(1, 8); t > 0; t--) begin
                        off = $urandom_range(0, 1) ? 16'($urandom_range(0, 40) - 20)
                                                    : 16'($urandom_range(0, 8000) - 4000);
                        send_request(OP_TICK, gx + off, gy - off / 2,
                                     16'(gh + $urandom_range(0, 3000) - 1500), 0, none);
                        n++;
                    end
                end
            end
            drain();
        end
        if (mismatches == 0 && cmd_queue.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
hdl/wgtg_pkg.sv
hdl/wgtg_cell.sv
hdl/wgtg_isqrt.sv
hdl/waypoint_go_to_goal_controller.sv
test/testbench.sv
